// ----- rtl/qred_pkg.sv -----
// qred_pkg: shared types, constants and the quarter-step table for the
// quadrature encoder detent decoder. No dependencies.
`timescale 1ns / 1ps

package qred_pkg;

  // Lanes that the pin words and flag fields carry
  localparam int LANES = 4;
  localparam int DEFAULT_NUM_ENCODERS = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam int PIN_W = 8;
  localparam int CNT_W = 8;
  localparam int DIV_W = 7;
  localparam int MASK_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [DIV_W-1:0] DIVISOR_RESET = 7'd4;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DETENT_DIV = 2'd2;

  // Configuration as seen by the front and back parts
  typedef struct packed {
    logic [MASK_W-1:0] enable_mask;
    logic [MASK_W-1:0] invert_mask;
    logic [DIV_W-1:0]  detent_divisor;
  } cfg_t;

  // One classified beat: per lane, whether the count moves and which way
  typedef struct packed {
    logic [LANES-1:0] move;
    logic [LANES-1:0] inc;
    logic [LANES-1:0] dec;
  } step_t;

  // Gray-transition table, index is the old two-bit pair times four plus
  // the fresh pair. Returns {inc, dec}; both clear means a zero step.
  function automatic logic [1:0] quarter_step(input logic [3:0] idx);
    logic [1:0] r;
    unique case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: r = 2'b01;
      4'd2, 4'd4, 4'd11, 4'd13: r = 2'b10;
      default: r = 2'b00;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/qred_front.sv -----
// qred_front: classifies a pin-sample beat into per-lane quarter steps.
// Depends on qred_pkg.
`timescale 1ns / 1ps

module qred_front
  import qred_pkg::*;
#(
  parameter int NUM_ENCODERS = DEFAULT_NUM_ENCODERS
) (
  input  cfg_t             cfg,
  input  logic [PIN_W-1:0] prior_pins,
  input  logic [PIN_W-1:0] new_pins,
  output step_t            step
);

  // Per lane: build the two-bit states, detect a change, look up the step
  always_comb begin
    logic [1:0] ps;
    logic [1:0] ns;
    logic [1:0] qs;
    logic       on;
    step = '0;
    for (int i = 0; i < LANES; i++) begin
      on = (i < NUM_ENCODERS) && cfg.enable_mask[i];
      if (cfg.invert_mask[i]) begin
        ps = {prior_pins[2*i], prior_pins[2*i+1]};
        ns = {new_pins[2*i], new_pins[2*i+1]};
      end else begin
        ps = {prior_pins[2*i+1], prior_pins[2*i]};
        ns = {new_pins[2*i+1], new_pins[2*i]};
      end
      qs = quarter_step({ps, ns});
      step.move[i] = on && (ps != ns);
      step.inc[i]  = qs[1];
      step.dec[i]  = qs[0];
    end
  end

endmodule

// ----- rtl/qred_queue.sv -----
// qred_queue: short register FIFO of classified beats between front and back.
// Depends on qred_pkg.
`timescale 1ns / 1ps

module qred_queue
  import qred_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  step_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output step_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  step_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] fill;

  assign full      = (fill == CNT_QW'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = mem[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CNT_QW'(push && !full) - CNT_QW'(pop && not_empty);
    end
  end

endmodule

// ----- rtl/qred_back.sv -----
// qred_back: per-lane sub-counters, detent thresholds and the output register.
// Depends on qred_pkg.
`timescale 1ns / 1ps

module qred_back
  import qred_pkg::*;
#(
  parameter int NUM_ENCODERS = DEFAULT_NUM_ENCODERS
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  step_t             in_step,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [MASK_W-1:0] out_up,
  output logic [MASK_W-1:0] out_down
);

  localparam int CNT_LANES = (NUM_ENCODERS < LANES) ? NUM_ENCODERS : LANES;

  logic                   take;
  logic [LANES-1:0]       up_hit;
  logic [LANES-1:0]       dn_hit;
  logic [LANES-1:0]       zero_lanes;
  logic signed [CNT_W:0]  lim;
  logic signed [CNT_W:0]  neg_lim;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign lim      = $signed({2'b00, cfg.detent_divisor});
  assign neg_lim  = -lim;

  // One counter lane per decoded encoder
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < CNT_LANES) begin : g_cnt
      logic signed [CNT_W-1:0] count;
      logic signed [CNT_W:0]   sum;

      always_comb begin
        sum = {count[CNT_W-1], count};
        if (in_step.inc[i]) begin
          sum = sum + (CNT_W+1)'(1);
        end else if (in_step.dec[i]) begin
          sum = sum - (CNT_W+1)'(1);
        end
      end

      assign up_hit[i]     = in_step.move[i] && (sum >= lim);
      assign dn_hit[i]     = in_step.move[i] && !up_hit[i] && (sum <= neg_lim);
      assign zero_lanes[i] = (count == '0);

      always_ff @(posedge clk) begin
        if (rst) begin
          count <= '0;
        end else if (take && in_step.move[i]) begin
          count <= (up_hit[i] || dn_hit[i]) ? '0 : sum[CNT_W-1:0];
        end
      end
    end else begin : g_none
      assign up_hit[i]     = 1'b0;
      assign dn_hit[i]     = 1'b0;
      assign zero_lanes[i] = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_up   <= up_hit;
      out_down <= dn_hit;
    end
  end

  // A lane never flags both ways in one beat
  a_no_both: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_up & out_down) == '0))
    else $error("up and down flag set on the same lane");

  // A lane that fired has a cleared count afterwards
  a_fire_clears: assert property (@(posedge clk) disable iff (rst)
    take |=> ((zero_lanes & $past(up_hit | dn_hit)) == $past(up_hit | dn_hit)))
    else $error("count not cleared after a detent");

  // A stalled result is not overwritten
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_up) && $stable(out_down)))
    else $error("pending result changed while stalled");

endmodule

// ----- rtl/quad_rotary_encoder_detent_decoder.sv -----
// quad_rotary_encoder_detent_decoder: top level, configuration registers
// and the front / queue / back chain. Depends on qred_pkg and the qred_* parts.
`timescale 1ns / 1ps

// Usage:
//   Slave channel s_*: one beat per pin sample pair, s_tdata holds
//   prior_pins (bits 7:0) and new_pins (bits 15:8). The front classifies
//   each beat into per-lane quarter steps and places it in a two-entry queue.
//   Master channel m_*: one beat per input beat, m_tdata holds up_flags
//   (bits 3:0) and down_flags (bits 7:4) for that input beat only.
//   An accepted beat is registered in the queue, then in the output register.
//   Throughput: one beat per cycle while m_tready is high; the back part
//   updates all counters of a beat at once, one add and two compares per lane.
//   Stall: while m_tready is low the result holds in the output register;
//   the queue fills, then s_tready drops until the receiver takes a beat.
//   Config: cfg_we writes cfg_data to register cfg_index (0 enable mask,
//   1 invert mask, 2 detent divisor); other indexes are ignored. Write only
//   when no beats are in flight.
//   Reset (rst, synchronous): counters cleared, queue and output emptied,
//   enable and invert masks zero, detent divisor four.
module quad_rotary_encoder_detent_decoder
  import qred_pkg::*;
#(
  parameter int NUM_ENCODERS = DEFAULT_NUM_ENCODERS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // prior_pins[7:0], new_pins[15:8]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata    // up_flags[3:0], down_flags[7:4]
);

  cfg_t  cfg;
  step_t front_step;
  step_t queue_step;
  logic  queue_full;
  logic  queue_valid;
  logic  back_ready;
  logic [MASK_W-1:0] up_flags;
  logic [MASK_W-1:0] down_flags;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_mask    <= '0;
      cfg.invert_mask    <= '0;
      cfg.detent_divisor <= DIVISOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE_MASK: cfg.enable_mask    <= cfg_data[MASK_W-1:0];
        REG_INVERT_MASK: cfg.invert_mask    <= cfg_data[MASK_W-1:0];
        REG_DETENT_DIV:  cfg.detent_divisor <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  qred_front #(.NUM_ENCODERS(NUM_ENCODERS)) u_front (
    .cfg        (cfg),
    .prior_pins (s_tdata[7:0]),
    .new_pins   (s_tdata[15:8]),
    .step       (front_step)
  );

  assign s_tready = !queue_full;

  qred_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid),
    .push_data (front_step),
    .full      (queue_full),
    .pop       (back_ready),
    .not_empty (queue_valid),
    .pop_data  (queue_step)
  );

  qred_back #(.NUM_ENCODERS(NUM_ENCODERS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (queue_valid),
    .in_ready  (back_ready),
    .in_step   (queue_step),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_up    (up_flags),
    .out_down  (down_flags)
  );

  assign m_tdata = {down_flags, up_flags};

endmodule
